FILE: rtl/assert_macros.svh
// Assertion macros shared by the frame receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CRCFR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CRCFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/crcfr_pkg.sv
// Types, constants and the CRC step function of the frame receiver.
`default_nettype none
package crcfr_pkg;

   localparam int PAYLOAD_BYTES = 32;
   localparam int RUN_LEN       = (PAYLOAD_BYTES < 32) ? PAYLOAD_BYTES : 32;
   localparam int STORE_AW      = 5;
   localparam int POS_W         = $clog2(PAYLOAD_BYTES + 1);
   localparam int CMDQ_DEPTH    = 2;
   localparam int CMDQ_AW       = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CW       = $clog2(CMDQ_DEPTH + 1);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB  = 16'h8000;

   localparam logic [7:0] FIRST_SYNC_RESET  = 8'hAA;
   localparam logic [7:0] SECOND_SYNC_RESET = 8'h55;
   localparam logic [7:0] CMD_TYPE_RESET    = 8'h01;

   typedef enum logic [1:0] {
      EV_PROGRESS   = 2'd0,
      EV_ACCEPT     = 2'd1,
      EV_HDR_REJECT = 2'd2,
      EV_CRC_BAD    = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      REG_FIRST_SYNC  = 2'd0,
      REG_SECOND_SYNC = 2'd1,
      REG_CMD_TYPE    = 2'd2
   } reg_index_type;

   typedef struct packed {
      event_type   ev;
      logic [31:0] good_count;
      logic [31:0] bad_count;
   } cmd_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } store_wr_type;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/crcfr_front.sv
// Front end: config registers, sync hunt, header check, CRC and payload store writes.
`default_nettype none
`include "assert_macros.svh"
module crcfr_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [1:0]             csr_index,
   input  wire logic [7:0]             csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_rx_byte,
   input  wire logic                   req_line_error,
   input  wire logic                   cmd_full,
   output logic                        cmd_push,
   output crcfr_pkg::cmd_type          cmd_data,
   output crcfr_pkg::store_wr_type     store_wr,
   input  wire logic                   run_done
);

   typedef enum logic [6:0] {
      PH_SYNC0   = 7'b0000001,
      PH_SYNC1   = 7'b0000010,
      PH_TYPE    = 7'b0000100,
      PH_LEN     = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_CRC_LO  = 7'b0100000,
      PH_CRC_HI  = 7'b1000000
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic [7:0]                     first_sync_ff, second_sync_ff, cmd_code_ff;
   logic [7:0]                     frame_type_ff, frame_type_in;
   logic [crcfr_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [7:0]                     crc_lo_ff, crc_lo_in;
   logic [15:0]                    crc_ff, crc_in;
   logic [31:0]                    good_ff, good_in, bad_ff, bad_in;
   logic                           busy_ff, busy_in;
   crcfr_pkg::event_type           ev;
   logic                           accept;

   assign csr_ready = 1'b1;
   assign req_stall = cmd_full || (phase_ff == PH_PAYLOAD && busy_ff);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_sync_ff  <= crcfr_pkg::FIRST_SYNC_RESET;
         second_sync_ff <= crcfr_pkg::SECOND_SYNC_RESET;
         cmd_code_ff    <= crcfr_pkg::CMD_TYPE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            crcfr_pkg::REG_FIRST_SYNC:  first_sync_ff  <= csr_wdata;
            crcfr_pkg::REG_SECOND_SYNC: second_sync_ff <= csr_wdata;
            crcfr_pkg::REG_CMD_TYPE:    cmd_code_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      frame_type_in = frame_type_ff;
      pos_in        = pos_ff;
      crc_lo_in     = crc_lo_ff;
      crc_in        = crc_ff;
      good_in       = good_ff;
      bad_in        = bad_ff;
      ev            = crcfr_pkg::EV_PROGRESS;
      store_wr      = '0;
      if (accept) begin
         if (req_line_error) begin
            phase_in = PH_SYNC0;
            pos_in   = '0;
         end else begin
            case (phase_ff)
               PH_SYNC0: begin
                  if (req_rx_byte == first_sync_ff) phase_in = PH_SYNC1;
               end
               PH_SYNC1: begin
                  if (req_rx_byte == second_sync_ff) begin
                     phase_in = PH_TYPE;
                     crc_in   = crcfr_pkg::CRC_INIT;
                  end else if (req_rx_byte != first_sync_ff) begin
                     phase_in = PH_SYNC0;
                  end
               end
               PH_TYPE: begin
                  frame_type_in = req_rx_byte;
                  crc_in        = crcfr_pkg::crc_fold(crcfr_pkg::CRC_INIT, req_rx_byte);
                  phase_in      = PH_LEN;
               end
               PH_LEN: begin
                  pos_in = '0;
                  crc_in = crcfr_pkg::crc_fold(crc_ff, req_rx_byte);
                  if (frame_type_ff == cmd_code_ff
                      && req_rx_byte == 8'(crcfr_pkg::PAYLOAD_BYTES)) begin
                     phase_in = PH_PAYLOAD;
                  end else begin
                     bad_in   = bad_ff + 32'd1;
                     ev       = crcfr_pkg::EV_HDR_REJECT;
                     phase_in = PH_SYNC0;
                  end
               end
               PH_PAYLOAD: begin
                  store_wr.en   = (pos_ff < crcfr_pkg::POS_W'(crcfr_pkg::RUN_LEN));
                  store_wr.addr = pos_ff[crcfr_pkg::STORE_AW-1:0];
                  store_wr.data = req_rx_byte;
                  crc_in        = crcfr_pkg::crc_fold(crc_ff, req_rx_byte);
                  pos_in        = pos_ff + crcfr_pkg::POS_W'(1);
                  if (pos_ff == crcfr_pkg::POS_W'(crcfr_pkg::PAYLOAD_BYTES - 1)) begin
                     phase_in = PH_CRC_LO;
                  end
               end
               PH_CRC_LO: begin
                  crc_lo_in = req_rx_byte;
                  phase_in  = PH_CRC_HI;
               end
               PH_CRC_HI: begin
                  phase_in = PH_SYNC0;
                  pos_in   = '0;
                  if (crc_ff == {req_rx_byte, crc_lo_ff}) begin
                     good_in = good_ff + 32'd1;
                     ev      = crcfr_pkg::EV_ACCEPT;
                  end else begin
                     bad_in = bad_ff + 32'd1;
                     ev     = crcfr_pkg::EV_CRC_BAD;
                  end
               end
               default: begin
                  phase_in = PH_SYNC0;
                  pos_in   = '0;
               end
            endcase
         end
      end
   end

   assign cmd_push            = accept;
   assign cmd_data.ev         = ev;
   assign cmd_data.good_count = good_in;
   assign cmd_data.bad_count  = bad_in;

   always_comb begin
      busy_in = busy_ff;
      if (run_done) busy_in = 1'b0;
      if (cmd_push && ev == crcfr_pkg::EV_ACCEPT) busy_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC0;
         frame_type_ff <= '0;
         pos_ff        <= '0;
         crc_lo_ff     <= '0;
         crc_ff        <= crcfr_pkg::CRC_INIT;
         good_ff       <= '0;
         bad_ff        <= '0;
         busy_ff       <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         frame_type_ff <= frame_type_in;
         pos_ff        <= pos_in;
         crc_lo_ff     <= crc_lo_in;
         crc_ff        <= crc_in;
         good_ff       <= good_in;
         bad_ff        <= bad_in;
         busy_ff       <= busy_in;
      end
   end

   // store must not be overwritten while a burst still reads it
   `CRCFR_ASSERT_NOW(a_store_guard, clock, reset, busy_ff && !run_done, !store_wr.en)
   `CRCFR_ASSERT_NOW(a_one_burst, clock, reset, busy_ff && !run_done,
                     !(cmd_push && cmd_data.ev == crcfr_pkg::EV_ACCEPT))

endmodule
`default_nettype wire

FILE: rtl/crcfr_cmd_fifo.sv
// Small command queue between front end and result emitter.
`default_nettype none
`include "assert_macros.svh"
module crcfr_cmd_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire crcfr_pkg::cmd_type push_data,
   input  wire logic               pop,
   output crcfr_pkg::cmd_type      head,
   output logic                    full,
   output logic                    empty
);

   crcfr_pkg::cmd_type                entry_ff [crcfr_pkg::CMDQ_DEPTH];
   logic [crcfr_pkg::CMDQ_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [crcfr_pkg::CMDQ_CW-1:0]     count_ff;

   localparam logic [crcfr_pkg::CMDQ_AW-1:0] LAST_PTR =
      crcfr_pkg::CMDQ_AW'(crcfr_pkg::CMDQ_DEPTH - 1);

   assign full  = (count_ff == crcfr_pkg::CMDQ_CW'(crcfr_pkg::CMDQ_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + crcfr_pkg::CMDQ_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + crcfr_pkg::CMDQ_AW'(1);
         end
         if (push && !pop)      count_ff <= count_ff + crcfr_pkg::CMDQ_CW'(1);
         else if (pop && !push) count_ff <= count_ff - crcfr_pkg::CMDQ_CW'(1);
      end
   end

   `CRCFR_ASSERT_NOW(a_no_overflow, clock, reset, push, !full)
   `CRCFR_ASSERT_NOW(a_no_underflow, clock, reset, pop, !empty)

endmodule
`default_nettype wire

FILE: rtl/crcfr_back.sv
// Result emitter: payload store, burst sequencer and output register.
`default_nettype none
`include "assert_macros.svh"
module crcfr_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire crcfr_pkg::store_wr_type store_wr,
   input  wire logic                    cmd_empty,
   input  wire crcfr_pkg::cmd_type      cmd_head,
   output logic                         cmd_pop,
   output logic                         run_done,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [1:0]                   rsp_event_code,
   output logic [7:0]                   rsp_payload_byte,
   output logic [4:0]                   rsp_payload_index,
   output logic                         rsp_last_of_run,
   output logic [31:0]                  rsp_good_frame_count,
   output logic [31:0]                  rsp_bad_frame_count
);

   localparam logic [crcfr_pkg::STORE_AW-1:0] LAST_IDX =
      crcfr_pkg::STORE_AW'(crcfr_pkg::RUN_LEN - 1);

   logic [7:0]                     store_mem [crcfr_pkg::RUN_LEN];
   logic                           run_ff;
   logic [crcfr_pkg::STORE_AW-1:0] run_idx_ff;
   crcfr_pkg::cmd_type             run_cmd_ff;
   logic                           s1_valid_ff, s1_last_ff;
   logic [crcfr_pkg::STORE_AW-1:0] s1_idx_ff;
   crcfr_pkg::cmd_type             s1_cmd_ff;
   logic [7:0]                     rd_data_ff;
   logic                           out_valid_ff, out_last_ff;
   logic [1:0]                     out_ev_ff;
   logic [7:0]                     out_byte_ff;
   logic [4:0]                     out_idx_ff;
   logic [31:0]                    out_good_ff, out_bad_ff;

   logic                           adv2, s1_free, issue_run, issue_pop, head_good;
   logic                           issue_last, s1_good;
   logic [crcfr_pkg::STORE_AW-1:0] issue_idx;

   assign adv2      = !out_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || adv2;
   assign issue_run = run_ff && s1_free;
   assign issue_pop = !run_ff && !cmd_empty && s1_free;
   assign head_good = (cmd_head.ev == crcfr_pkg::EV_ACCEPT);
   assign issue_idx = run_ff ? run_idx_ff : '0;
   assign cmd_pop   = issue_pop;

   always_comb begin
      if (run_ff)         issue_last = (run_idx_ff == LAST_IDX);
      else if (head_good) issue_last = (crcfr_pkg::RUN_LEN == 1);
      else                issue_last = 1'b1;
   end

   assign run_done = (issue_run || (issue_pop && head_good)) && issue_last;

   always_ff @(posedge clock) begin
      if (store_wr.en) store_mem[store_wr.addr] <= store_wr.data;
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         rd_data_ff <= store_mem[issue_idx];
         s1_cmd_ff  <= run_ff ? run_cmd_ff : cmd_head;
         s1_idx_ff  <= issue_idx;
         s1_last_ff <= issue_last;
      end
      if (issue_pop) run_cmd_ff <= cmd_head;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         run_idx_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (s1_free) s1_valid_ff <= issue_run || issue_pop;
         if (issue_run) begin
            run_idx_ff <= run_idx_ff + crcfr_pkg::STORE_AW'(1);
            if (issue_last) run_ff <= 1'b0;
         end else if (issue_pop && head_good && !issue_last) begin
            run_ff     <= 1'b1;
            run_idx_ff <= crcfr_pkg::STORE_AW'(1);
         end
      end
   end

   assign s1_good = (s1_cmd_ff.ev == crcfr_pkg::EV_ACCEPT);

   always_ff @(posedge clock) begin
      if (adv2) begin
         out_ev_ff   <= s1_cmd_ff.ev;
         out_byte_ff <= s1_good ? rd_data_ff : 8'h00;
         out_idx_ff  <= s1_good ? 5'(s1_idx_ff) : 5'd0;
         out_last_ff <= s1_last_ff;
         out_good_ff <= s1_cmd_ff.good_count;
         out_bad_ff  <= s1_cmd_ff.bad_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv2) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_event_code       = out_ev_ff;
   assign rsp_payload_byte     = out_byte_ff;
   assign rsp_payload_index    = out_idx_ff;
   assign rsp_last_of_run      = out_last_ff;
   assign rsp_good_frame_count = out_good_ff;
   assign rsp_bad_frame_count  = out_bad_ff;

   `CRCFR_ASSERT_NOW(a_plain_result, clock, reset,
                     out_valid_ff && out_ev_ff != crcfr_pkg::EV_ACCEPT,
                     out_byte_ff == 8'h00 && out_idx_ff == 5'd0 && out_last_ff)
   `CRCFR_ASSERT_NEXT(a_run_ends, clock, reset, issue_run && issue_last, !run_ff)

endmodule
`default_nettype wire

FILE: rtl/crc_checked_frame_receiver_core.sv
// Top level of the sync-header frame receiver with CRC-16 check.
`default_nettype none
// Receives one serial byte per item, hunts for the two configured sync bytes,
// checks the type and length header, buffers the 32-byte payload and checks a
// CRC-16 (poly 0x1021, init 0xFFFF, sent low byte first) over type, length and
// payload. Each byte item yields one result, except the closing byte of a good
// frame, which yields 32 payload results, the last one marked. The front end
// takes one byte per cycle; it stalls on the first payload byte of a frame
// while the previous good frame's payload is still being read out of the
// single payload store, and whenever the two-entry command queue is full. The
// emitter delivers one result per cycle while the output is not stalled. An
// item's first result passes through the command queue, the store-read
// register and the output register. Config writes are always ready and are
// registered, so a byte taken with a write still sees the old value.
module crc_checked_frame_receiver_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_line_error,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_event_code,
   output logic [7:0]       rsp_payload_byte,
   output logic [4:0]       rsp_payload_index,
   output logic             rsp_last_of_run,
   output logic [31:0]      rsp_good_frame_count,
   output logic [31:0]      rsp_bad_frame_count
);

   crcfr_pkg::cmd_type      cmd_push_data, cmd_head;
   crcfr_pkg::store_wr_type store_wr;
   logic                    cmd_push, cmd_pop, cmd_full, cmd_empty, run_done;

   crcfr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .req_line_error (req_line_error),
      .cmd_full       (cmd_full),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_push_data),
      .store_wr       (store_wr),
      .run_done       (run_done)
   );

   crcfr_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .full      (cmd_full),
      .empty     (cmd_empty)
   );

   crcfr_back u_back (
      .clock                (clock),
      .reset                (reset),
      .store_wr             (store_wr),
      .cmd_empty            (cmd_empty),
      .cmd_head             (cmd_head),
      .cmd_pop              (cmd_pop),
      .run_done             (run_done),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_code       (rsp_event_code),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_payload_index    (rsp_payload_index),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_good_frame_count (rsp_good_frame_count),
      .rsp_bad_frame_count  (rsp_bad_frame_count)
   );

endmodule
`default_nettype wire
